// ===== rtl/hsfp_pkg.sv =====
// Shared types, widths and constants for the five-point heat stencil step.
package hsfp_pkg;

  localparam int MAX_GRID   = 1024;
  localparam int COL_W      = $clog2(MAX_GRID);
  localparam int GRID_W     = 11;
  localparam int CNT_W      = (COL_W + 1 > GRID_W) ? COL_W + 1 : GRID_W;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 16;
  localparam int CFG_W      = 16;
  localparam int R2_W       = COEF_W + 3;
  localparam int SUM_W      = DATA_W + 2;
  localparam int PROD_W     = DATA_W + R2_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_SHIFT = 16;
  localparam int Q_W        = ACC_W - FRAC_SHIFT;
  localparam int MEM_W      = 2 * DATA_W;

  localparam logic [GRID_W-1:0] N_CLAMP =
    GRID_W'((MAX_GRID < 2 ** GRID_W) ? MAX_GRID : 2 ** GRID_W - 1);
  localparam logic [GRID_W-1:0] N_RESET =
    GRID_W'((MAX_GRID < 1024) ? MAX_GRID : 1024);

  localparam logic signed [R2_W-1:0]   R2_ONE     = R2_W'(65536);
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(32768);
  localparam logic signed [DATA_W-1:0] SAT_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [0:0] {
    CFG_GRID_SIZE = 1'b0,
    CFG_COEFF_R   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] sample;
    logic                     emit;
    logic                     drain;
    logic                     up_zero;
    logic                     left_zero;
    logic                     right_zero;
    logic                     last;
  } p1_item_t;

endpackage

// ===== rtl/hsfp_ram.sv =====
// Generic single-write, dual-read synchronous RAM with registered read data.
module hsfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0_r <= mem[raddr0];
      rdata1_r <= mem[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ===== rtl/hsfp_arith.sv =====
// Stencil multiply stage with rounding and saturation of the weighted sum.
module hsfp_arith (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [hsfp_pkg::DATA_W-1:0] c_in,
  input  logic signed [hsfp_pkg::SUM_W-1:0]  nsum_in,
  input  logic signed [hsfp_pkg::R2_W-1:0]   r2,
  input  logic [hsfp_pkg::COEF_W-1:0]        coef,
  output logic signed [hsfp_pkg::DATA_W-1:0] value
);
  import hsfp_pkg::*;

  logic signed [PROD_W-1:0] prod_c_r;
  logic signed [PROD_W-1:0] prod_n_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [Q_W-1:0]    q;
  logic [Q_W-DATA_W:0]      q_hi;
  logic                     ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_c_r <= PROD_W'(r2) * PROD_W'(c_in);
      prod_n_r <= PROD_W'($signed({1'b0, coef})) * PROD_W'(nsum_in);
    end
  end

  always_comb begin
    acc   = ACC_W'(prod_c_r) + ACC_W'(prod_n_r) + ROUND_HALF;
    q     = acc[ACC_W-1:FRAC_SHIFT];
    q_hi  = q[Q_W-1:DATA_W-1];
    ovf   = !((&q_hi) || !(|q_hi));
    if (ovf) begin
      value = q[Q_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      value = q[DATA_W-1:0];
    end
  end

endmodule

// ===== rtl/heat_stencil_five_point_step_top.sv =====
// Five-point heat stencil step over a raster-streamed grid with two row stores.
// Throughput: one item per cycle while in_stall is low, set by the single
//   read-modify-write pass over the row memory (two read ports, one write
//   port) per item. Registers in order: p1, p2, multiply products, output.
// Output register plus skid entry; in_stall rises only when both are full.
// Reset clears counters, left hold, valids and config; row memory is not cleared.
module heat_stencil_five_point_step_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [hsfp_pkg::DATA_W-1:0] in_sample,
  input  logic                               in_drain,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [hsfp_pkg::DATA_W-1:0] out_value,
  output logic                               out_last_of_grid,
  input  logic                               cfg_we,
  input  hsfp_pkg::cfg_idx_t                 cfg_index,
  input  logic [hsfp_pkg::CFG_W-1:0]         cfg_wdata
);
  import hsfp_pkg::*;

  logic [GRID_W-1:0]        n_r;
  logic [COEF_W-1:0]        coeff_r_r;
  logic signed [R2_W-1:0]   r2_r;
  logic [GRID_W-1:0]        grid_req;
  logic [GRID_W-1:0]        grid_eff;

  logic [COL_W-1:0]         col_r, col_nxt;
  logic [GRID_W-1:0]        row_r, row_nxt;
  logic [CNT_W-1:0]         col_inc;
  logic                     col_last;
  logic                     active;
  logic                     in_fire;
  logic                     adv;

  p1_item_t                 p1_nxt, p1_r;
  logic                     p1_v_r, p1_v_nxt;
  logic                     fwd0_r, fwd1_r;
  logic [MEM_W-1:0]         fwd_data_r;
  logic signed [DATA_W-1:0] left_hold_r;

  logic                     wr_en;
  logic [MEM_W-1:0]         wr_data;
  logic [COL_W-1:0]         raddr1;
  logic [MEM_W-1:0]         rd0, rd1;
  logic [MEM_W-1:0]         here_word;
  logic signed [DATA_W-1:0] c_eff, up_eff, right_eff;
  logic signed [DATA_W-1:0] up_v, down_v, left_v, right_v;
  logic signed [SUM_W-1:0]  nsum;

  logic signed [DATA_W-1:0] p2_c_r;
  logic signed [SUM_W-1:0]  p2_nsum_r;
  logic                     p2_last_r;
  logic                     p2_v_r, p2_v_nxt;
  logic                     p3_last_r;
  logic                     p3_v_r, p3_v_nxt;
  logic signed [DATA_W-1:0] res_value;

  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_v_r, out_v_nxt;
  logic signed [DATA_W-1:0] skid_value_r, skid_value_nxt;
  logic                     skid_last_r, skid_last_nxt;
  logic                     skid_v_r, skid_v_nxt;

  // configuration registers
  always_comb begin
    grid_req = cfg_wdata[GRID_W-1:0];
    if (grid_req == '0) begin
      grid_eff = GRID_W'(1);
    end else if (32'(grid_req) > MAX_GRID) begin
      grid_eff = N_CLAMP;
    end else begin
      grid_eff = grid_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= N_RESET;
      coeff_r_r <= '0;
      r2_r      <= R2_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SIZE: begin
          n_r <= grid_eff;
        end
        CFG_COEFF_R: begin
          coeff_r_r <= cfg_wdata[COEF_W-1:0];
          r2_r      <= R2_ONE - $signed({1'b0, cfg_wdata[COEF_W-1:0], 2'b00});
        end
        default: begin
        end
      endcase
    end
  end

  // accept stage: raster counters and per-item flags
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    col_inc  = CNT_W'(col_r) + CNT_W'(1);
    col_last = col_inc >= CNT_W'(n_r);
    active   = (row_r < n_r) ? !in_drain : in_drain;

    p1_nxt.col        = col_r;
    p1_nxt.sample     = in_sample;
    p1_nxt.drain      = in_drain;
    p1_nxt.emit       = in_drain || (row_r != '0);
    p1_nxt.up_zero    = in_drain ? (n_r == GRID_W'(1)) : (row_r < GRID_W'(2));
    p1_nxt.left_zero  = (col_r == '0);
    p1_nxt.right_zero = col_last;
    p1_nxt.last       = in_drain && col_last;

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire && active) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = in_drain ? '0 : row_r + GRID_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end

    if (in_fire) begin
      p1_v_nxt = active;
    end else if (adv) begin
      p1_v_nxt = 1'b0;
    end else begin
      p1_v_nxt = p1_v_r;
    end
  end

  // row memory: {upper, centre} per column
  assign raddr1  = col_r + COL_W'(1);
  assign wr_en   = adv && p1_v_r && !p1_r.drain;
  assign wr_data = {c_eff, p1_r.sample};

  hsfp_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_GRID)
  ) u_row_ram (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (p1_r.col),
    .wdata  (wr_data),
    .re     (adv),
    .raddr0 (col_r),
    .raddr1 (raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      p1_v_r      <= 1'b0;
      fwd0_r      <= 1'b0;
      fwd1_r      <= 1'b0;
      left_hold_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      p1_v_r <= p1_v_nxt;
      if (adv) begin
        fwd0_r <= wr_en && (p1_r.col == col_r);
        fwd1_r <= wr_en && (p1_r.col == raddr1);
        if (p1_v_r) begin
          left_hold_r <= c_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_r <= p1_nxt;
    end
    if (adv) begin
      fwd_data_r <= wr_data;
    end
  end

  // neighbor gather with forwarding of the write that raced the read
  always_comb begin
    here_word = fwd0_r ? fwd_data_r : rd0;
    c_eff     = here_word[DATA_W-1:0];
    up_eff    = here_word[MEM_W-1:DATA_W];
    right_eff = fwd1_r ? fwd_data_r[DATA_W-1:0] : rd1[DATA_W-1:0];
    up_v      = p1_r.up_zero    ? '0 : up_eff;
    down_v    = p1_r.drain      ? '0 : p1_r.sample;
    left_v    = p1_r.left_zero  ? '0 : left_hold_r;
    right_v   = p1_r.right_zero ? '0 : right_eff;
    nsum      = SUM_W'(up_v) + SUM_W'(down_v) + SUM_W'(left_v) + SUM_W'(right_v);
    p2_v_nxt  = adv ? (p1_v_r && p1_r.emit) : p2_v_r;
    p3_v_nxt  = adv ? p2_v_r : p3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p2_v_r <= p2_v_nxt;
      p3_v_r <= p3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_c_r    <= c_eff;
      p2_nsum_r <= nsum;
      p2_last_r <= p1_r.last;
      p3_last_r <= p2_last_r;
    end
  end

  hsfp_arith u_arith (
    .clk     (clk),
    .en      (adv),
    .c_in    (p2_c_r),
    .nsum_in (p2_nsum_r),
    .r2      (r2_r),
    .coef    (coeff_r_r),
    .value   (res_value)
  );

  // output register and skid entry
  always_comb begin
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_v_nxt      = out_v_r;
    skid_value_nxt = skid_value_r;
    skid_last_nxt  = skid_last_r;
    skid_v_nxt     = skid_v_r;
    if (out_v_r && !out_stall) begin
      if (skid_v_r) begin
        out_value_nxt = skid_value_r;
        out_last_nxt  = skid_last_r;
        skid_v_nxt    = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
    if (adv && p3_v_r) begin
      if (out_v_r && out_stall) begin
        skid_value_nxt = res_value;
        skid_last_nxt  = p3_last_r;
        skid_v_nxt     = 1'b1;
      end else begin
        out_value_nxt = res_value;
        out_last_nxt  = p3_last_r;
        out_v_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    skid_value_r <= skid_value_nxt;
    skid_last_r  <= skid_last_nxt;
  end

  assign out_valid        = out_v_r;
  assign out_value        = out_value_r;
  assign out_last_of_grid = out_last_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid entry held without a pending output item");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_stall))
    else $error("skid entry filled while output was not stalled");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (p3_v_r && !in_stall) |=> out_valid)
    else $error("finished item did not reach the output register");

endmodule
